### rtl/core/fixed_delimiter_splitter_core_assert.svh
// assertion macros for the delimiter splitter
// used by the top level; no other dependencies
`ifndef FIXED_DELIMITER_SPLITTER_CORE_ASSERT_SVH
`define FIXED_DELIMITER_SPLITTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FDS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDS_ASSERT(lbl, clk, rstn, prop, msg)
`define FDS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/fds_pkg.sv
// shared types and constants for the delimiter splitter
// no dependencies
package fds_pkg;

    localparam int MAX_DELIM = 8;
    localparam int WIN_W     = 8 * MAX_DELIM;
    localparam int LEN_W     = 16;
    localparam logic [LEN_W-1:0] MAX_LEN = 16'hFFFF;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] REG_DELIM_BYTES = 3'd0;
    localparam logic [2:0] REG_DELIM_LEN   = 3'd1;
    localparam logic [2:0] REG_MAX_PIECES  = 3'd2;
    localparam logic [2:0] REG_UNLIMITED   = 3'd3;
    localparam logic [2:0] REG_OMIT_EMPTY  = 3'd4;

    typedef struct packed {
        logic [WIN_W-1:0] delim_bytes;
        logic [3:0]       delim_len;
        logic [15:0]      max_pieces;
        logic             unlimited;
        logic             omit_empty;
    } t_cfg;

    // one accepted item's worth of results: an optional inner piece and an
    // optional closing result
    typedef struct packed {
        logic             piece_valid;
        logic [LEN_W-1:0] p_start;
        logic [LEN_W-1:0] p_len;
        logic             end_valid;
        logic [LEN_W-1:0] e_start;
        logic [LEN_W-1:0] e_len;
        logic             e_none;
    } t_entry;

endpackage

### rtl/core/fixed_delimiter_splitter_core.sv
// Splits byte strings on a programmable delimiter of 1 to 8 bytes and reports
// each piece as start offset and length. One byte is taken per cycle: the
// delimiter compare over the byte window is done in parallel in the front
// end in the cycle the byte is accepted. An item gives at most two results
// (an inner piece and the closing result at string end); these go into a
// 4-entry queue that the result side drains at one result per cycle, so the
// input only waits when that queue fills. Results show up in the cycle after
// the item that caused them. Configuration is meant to be written between
// strings. No clearing pass is needed after reset.
// depends on fds_pkg, fds_regs, fds_front, fds_back and the assertion header
`include "fixed_delimiter_splitter_core_assert.svh"

module fixed_delimiter_splitter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_byte_valid,
    input  logic                        i_string_end,
    output logic                        empty,
    input  logic                        pop,
    output logic [15:0]                 o_piece_start,
    output logic [15:0]                 o_piece_length,
    output logic                        o_last_piece,
    output logic                        o_no_pieces,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fds_pkg::ADDR_W-1:0]  paddr,
    input  logic [fds_pkg::DATA_W-1:0]  pwdata,
    output logic [fds_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    fds_pkg::t_cfg   cfg;
    fds_pkg::t_entry entry;
    logic            wr;
    logic            accept;

    assign accept = push && !full;

    fds_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fds_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_string_end (i_string_end),
        .o_wr         (wr),
        .o_entry      (entry)
    );

    fds_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (wr),
        .i_entry        (entry),
        .o_full         (full),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_piece_start  (o_piece_start),
        .o_piece_length (o_piece_length),
        .o_last_piece   (o_last_piece),
        .o_no_pieces    (o_no_pieces)
    );

    `FDS_ASSERT(a_full_not_empty, i_clk, i_rst_n, !(full && empty), "queue both full and empty")
    `FDS_ASSERT(a_none_is_last, i_clk, i_rst_n, (!empty && o_no_pieces) |-> (o_last_piece && o_piece_start == 16'd0 && o_piece_length == 16'd0), "no-pieces marker malformed")
    `FDS_ASSERT(a_piece_in_range, i_clk, i_rst_n, !empty |-> ((17'(o_piece_start) + 17'(o_piece_length)) <= 17'(fds_pkg::MAX_LEN)), "piece runs past max length")

endmodule

### rtl/core/fds_regs.sv
// configuration registers behind the apb-style port
// depends on fds_pkg
module fds_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fds_pkg::ADDR_W-1:0]  paddr,
    input  logic [fds_pkg::DATA_W-1:0]  pwdata,
    output logic [fds_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output fds_pkg::t_cfg               o_cfg
);

    fds_pkg::t_cfg r_cfg;
    fds_pkg::t_cfg n_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                fds_pkg::REG_DELIM_BYTES: n_cfg.delim_bytes = pwdata[fds_pkg::WIN_W-1:0];
                fds_pkg::REG_DELIM_LEN:   n_cfg.delim_len   = pwdata[3:0];
                fds_pkg::REG_MAX_PIECES:  n_cfg.max_pieces  = pwdata[15:0];
                fds_pkg::REG_UNLIMITED:   n_cfg.unlimited   = pwdata[0];
                fds_pkg::REG_OMIT_EMPTY:  n_cfg.omit_empty  = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            fds_pkg::REG_DELIM_BYTES: prdata = fds_pkg::DATA_W'(r_cfg.delim_bytes);
            fds_pkg::REG_DELIM_LEN:   prdata = fds_pkg::DATA_W'(r_cfg.delim_len);
            fds_pkg::REG_MAX_PIECES:  prdata = fds_pkg::DATA_W'(r_cfg.max_pieces);
            fds_pkg::REG_UNLIMITED:   prdata = fds_pkg::DATA_W'(r_cfg.unlimited);
            fds_pkg::REG_OMIT_EMPTY:  prdata = fds_pkg::DATA_W'(r_cfg.omit_empty);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delim_bytes <= '0;
            r_cfg.delim_len   <= 4'd1;
            r_cfg.max_pieces  <= '0;
            r_cfg.unlimited   <= 1'b1;
            r_cfg.omit_empty  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### rtl/core/fds_front.sv
// front end: takes string bytes, runs the delimiter match and piece limit,
// and hands per-item results to the back end; depends on fds_pkg
module fds_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  fds_pkg::t_cfg          i_cfg,
    input  logic                   i_accept,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_byte_valid,
    input  logic                   i_string_end,
    output logic                   o_wr,
    output fds_pkg::t_entry        o_entry
);

    logic [fds_pkg::WIN_W-1:0] r_win, n_win;
    logic [fds_pkg::LEN_W-1:0] r_pos, n_pos;
    logic [fds_pkg::LEN_W-1:0] r_seg, n_seg;
    logic [15:0]               r_pe, n_pe;
    logic                      r_lr, n_lr;

    logic [3:0]                eff_len;
    logic                      zero_limit;
    logic [fds_pkg::WIN_W-1:0] win_shift;
    logic [fds_pkg::WIN_W-1:0] tail;
    logic [fds_pkg::WIN_W-1:0] mask;
    logic [6:0]                shamt;
    logic                      match;
    logic [fds_pkg::LEN_W-1:0] after;
    logic [fds_pkg::LEN_W-1:0] span;
    logic [fds_pkg::LEN_W-1:0] piece_len;
    fds_pkg::t_entry           ent;

    // one more piece would reach the limit
    function automatic logic at_limit(input logic [15:0] pe, input fds_pkg::t_cfg cfg);
        logic r;
        r = !cfg.unlimited && (cfg.max_pieces != 16'd0)
            && (({1'b0, pe} + 17'd1) >= {1'b0, cfg.max_pieces});
        return r;
    endfunction

    always_comb begin
        if (i_cfg.delim_len == 4'd0)
            eff_len = 4'd1;
        else if (i_cfg.delim_len > 4'(fds_pkg::MAX_DELIM))
            eff_len = 4'(fds_pkg::MAX_DELIM);
        else
            eff_len = i_cfg.delim_len;
    end

    assign zero_limit = !i_cfg.unlimited && (i_cfg.max_pieces == 16'd0);
    assign win_shift  = {i_data_byte, r_win[fds_pkg::WIN_W-1:8]};
    assign shamt      = 7'(fds_pkg::WIN_W) - {eff_len, 3'b000};
    assign tail       = win_shift >> shamt;

    always_comb begin
        for (int k = 0; k < fds_pkg::MAX_DELIM; k++) begin
            mask[8*k +: 8] = (4'(k) < eff_len) ? 8'hFF : 8'h00;
        end
    end

    assign match     = (tail == (i_cfg.delim_bytes & mask));
    assign after     = (r_pos != fds_pkg::MAX_LEN) ? r_pos + 16'd1 : r_pos;
    assign span      = after - r_seg;
    assign piece_len = span - 16'(eff_len);

    always_comb begin
        n_win = r_win;
        n_pos = r_pos;
        n_seg = r_seg;
        n_pe  = r_pe;
        n_lr  = r_lr;
        ent   = '0;
        if (i_accept) begin
            if (i_byte_valid) begin
                n_win = win_shift;
                n_pos = after;
                if (!zero_limit && !r_lr) begin
                    if (at_limit(r_pe, i_cfg)) begin
                        n_lr = 1'b1;
                    end else if ((span >= 16'(eff_len)) && match) begin
                        if (!i_cfg.omit_empty || (piece_len != '0)) begin
                            ent.piece_valid = 1'b1;
                            ent.p_start     = r_seg;
                            ent.p_len       = piece_len;
                            if (r_pe != 16'hFFFF)
                                n_pe = r_pe + 16'd1;
                        end
                        n_seg = after;
                        if (at_limit(n_pe, i_cfg))
                            n_lr = 1'b1;
                    end
                end
            end
            if (i_string_end) begin
                ent.end_valid = 1'b1;
                if (zero_limit) begin
                    ent.e_none = 1'b1;
                end else if (n_lr || at_limit(n_pe, i_cfg) || !i_cfg.omit_empty
                             || (n_pos > n_seg)) begin
                    ent.e_start = n_seg;
                    ent.e_len   = n_pos - n_seg;
                end else begin
                    // nothing left but delimiters or an empty string
                    ent.e_none = 1'b1;
                end
                n_win = '0;
                n_pos = '0;
                n_seg = '0;
                n_pe  = '0;
                n_lr  = 1'b0;
            end
        end
    end

    assign o_wr    = ent.piece_valid || ent.end_valid;
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_pos <= '0;
            r_seg <= '0;
            r_pe  <= '0;
            r_lr  <= 1'b0;
        end else begin
            r_win <= n_win;
            r_pos <= n_pos;
            r_seg <= n_seg;
            r_pe  <= n_pe;
            r_lr  <= n_lr;
        end
    end

endmodule

### rtl/core/fds_back.sv
// back end: queue of per-item results, drained one result per transfer
// depends on fds_pkg
module fds_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  fds_pkg::t_entry             i_entry,
    output logic                        o_full,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [fds_pkg::LEN_W-1:0]   o_piece_start,
    output logic [fds_pkg::LEN_W-1:0]   o_piece_length,
    output logic                        o_last_piece,
    output logic                        o_no_pieces
);

    fds_pkg::t_entry            r_mem [fds_pkg::QDEPTH];
    logic [fds_pkg::QAW-1:0]    r_wptr, n_wptr;
    logic [fds_pkg::QAW-1:0]    r_rptr, n_rptr;
    logic [fds_pkg::QCW-1:0]    r_count, n_count;
    logic                       r_sub, n_sub;

    fds_pkg::t_entry            head;
    logic                       show_piece;
    logic                       take;
    logic                       deq;

    assign head       = r_mem[r_rptr];
    assign o_full     = (r_count == fds_pkg::QCW'(fds_pkg::QDEPTH));
    assign o_empty    = (r_count == '0);
    // inner piece goes first, the closing result after it
    assign show_piece = head.piece_valid && !r_sub;
    assign take       = i_pop && !o_empty;
    assign deq        = take && (!show_piece || !head.end_valid);

    assign o_piece_start  = show_piece ? head.p_start : head.e_start;
    assign o_piece_length = show_piece ? head.p_len : head.e_len;
    assign o_last_piece   = !show_piece;
    assign o_no_pieces    = !show_piece && head.e_none;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        n_sub   = r_sub;
        if (i_wr) begin
            n_wptr = (r_wptr == fds_pkg::QAW'(fds_pkg::QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (deq) begin
            n_rptr = (r_rptr == fds_pkg::QAW'(fds_pkg::QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            n_sub  = 1'b0;
        end else if (take) begin
            n_sub = 1'b1;
        end
        if (i_wr && !deq)
            n_count = r_count + 1'b1;
        else if (!i_wr && deq)
            n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr)
            r_mem[r_wptr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
            r_sub   <= 1'b0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
            r_sub   <= n_sub;
        end
    end

endmodule
